// ===== src/tmp_pkg.sv =====
// Shared types, constants and helpers of the trapezoidal motion profile block.
`default_nettype none
package tmp_pkg;

	localparam int ValueWidth = 32;
	localparam int TimeWidth  = 25;
	localparam int CfgWidth   = 31;
	localparam int CfgIdxWidth = 3;
	localparam int CfgDataWidth = 32;
	localparam int IterWidth  = 7;
	localparam int RootSteps  = 33;
	localparam int DivSteps   = 64;

	localparam logic [CfgIdxWidth-1:0] CFG_MAX_VEL = 3'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_MAX_ACC = 3'd1;
	localparam logic [CfgIdxWidth-1:0] CFG_MAX_DT  = 3'd2;
	localparam logic [CfgIdxWidth-1:0] CFG_POS_TOL = 3'd3;
	localparam logic [CfgIdxWidth-1:0] CFG_VEL_TOL = 3'd4;

	localparam logic [CfgWidth-1:0]  RST_MAX_VEL = 31'd655360;
	localparam logic [CfgWidth-1:0]  RST_MAX_ACC = 31'd6553600;
	localparam logic [TimeWidth-1:0] RST_MAX_DT  = 25'd167772;
	localparam logic [CfgWidth-1:0]  RST_POS_TOL = 31'd66;
	localparam logic [CfgWidth-1:0]  RST_VEL_TOL = 31'd655;

	localparam logic signed [64:0] ValMax = 65'sd2147483647;
	localparam logic signed [64:0] ValMin = -ValMax - 65'sd1;

	typedef enum logic [1:0] {
		KIND_INIT   = 2'd0,
		KIND_TARGET = 2'd1,
		KIND_STOP   = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                         kind;
		logic signed [ValueWidth-1:0]  start_position;
		logic signed [ValueWidth-1:0]  goal_position;
		logic        [TimeWidth-1:0]   elapsed_time;
	} item_t;

	typedef struct packed {
		logic                          ok;
		logic signed [ValueWidth-1:0]  position_out;
		logic signed [ValueWidth-1:0]  velocity_out;
		logic                          settled;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_MUL_DT, S_ROOT, S_VEL, S_MUL_STEP, S_POS,
		S_DIV_LOAD, S_DIV, S_STOP_ADD, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_INIT, OP_SET_TARGET, OP_REJECT, OP_SNAP,
		OP_MUL_ERR, OP_MUL_DT, OP_ROOT_STEP, OP_VEL, OP_MUL_STEP, OP_POS,
		OP_MUL_STOP, OP_DIV_LOAD, OP_DIV_STEP, OP_STOP_ADD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  initialized;
		logic  cfg_ok;
		logic  dt_ok;
		logic  in_band;
		logic  iter_last;
	} dp_status_t;

	typedef struct packed {
		logic                         ovf;
		logic signed [ValueWidth-1:0] v;
	} sat_t;

	function automatic sat_t sat_value(input logic signed [64:0] x);
		sat_t r;
		if (x > ValMax) begin
			r.ovf = 1'b1;
			r.v   = ValMax[ValueWidth-1:0];
		end else if (x < ValMin) begin
			r.ovf = 1'b1;
			r.v   = ValMin[ValueWidth-1:0];
		end else begin
			r.ovf = 1'b0;
			r.v   = x[ValueWidth-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/trapezoidal_motion_profile.sv =====
// Each event is loaded and decoded; a tick that is neither rejected nor snapped then runs the
//   33-step bit-serial square root, and a stop the 64-step restoring divide, before the result
//   beat is loaded. One event at a time: the next beat is taken the cycle after the result is
//   loaded.
// Reset (arst_n low): idle, output empty, state zeroed and not initialized, config at defaults.
`default_nettype none
module trapezoidal_motion_profile (
	input  wire                              clk,
	input  wire                              arst_n,
	// event channel
	input  wire                              in_valid,
	output logic                             in_stall,
	input  tmp_pkg::item_t                   in_data,
	// result channel
	output logic                             out_valid,
	input  wire                              out_stall,
	output tmp_pkg::result_t                 out_data,
	// configuration write channel
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [tmp_pkg::CfgIdxWidth-1:0]   cfg_index,
	input  wire [tmp_pkg::CfgDataWidth-1:0]  cfg_data
);
	import tmp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	// Config beats land directly in the datapath; taken only while idle with no
	// event beat offered, so no event ever sees a register change mid-flight.
	assign cfg_ready = !in_stall && !in_valid;

	// Sequencer: owns the handshakes and steps the datapath per event kind.
	tmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: holds the item, the motion state, the result register and the
	// shared multiplier plus root/divide iteration registers.
	tmp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== src/tmp_ctrl.sv =====
// Sequencer of the motion profile: walks each event through the datapath steps.
`default_nettype none
module tmp_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire                 out_stall,
	input  tmp_pkg::dp_status_t st,
	output tmp_pkg::dp_cmd_t    cmd
);
	import tmp_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				unique case (st.kind)
					KIND_INIT: cmd.op = OP_INIT;
					KIND_TARGET: cmd.op = st.initialized ? OP_SET_TARGET : OP_REJECT;
					KIND_STOP: begin
						if (st.initialized && st.cfg_ok) begin
							cmd.op  = OP_MUL_STOP;
							state_d = S_DIV_LOAD;
						end else begin
							cmd.op = OP_REJECT;
						end
					end
					default: begin
						if (!(st.initialized && st.cfg_ok && st.dt_ok)) begin
							cmd.op = OP_REJECT;
						end else if (st.in_band) begin
							cmd.op = OP_SNAP;
						end else begin
							cmd.op  = OP_MUL_ERR;
							state_d = S_MUL_DT;
						end
					end
				endcase
			end
			S_MUL_DT: begin
				cmd.op  = OP_MUL_DT;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.op = OP_ROOT_STEP;
				if (st.iter_last)
					state_d = S_VEL;
			end
			S_VEL: begin
				cmd.op  = OP_VEL;
				state_d = S_MUL_STEP;
			end
			S_MUL_STEP: begin
				cmd.op  = OP_MUL_STEP;
				state_d = S_POS;
			end
			S_POS: begin
				cmd.op  = OP_POS;
				state_d = S_DONE;
			end
			S_DIV_LOAD: begin
				cmd.op  = OP_DIV_LOAD;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (st.iter_last)
					state_d = S_STOP_ADD;
			end
			S_STOP_ADD: begin
				cmd.op  = OP_STOP_ADD;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DECODE))
		else $error("accepted beat did not move to decode");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> (state_q == S_DONE))
		else $error("result dropped while output stalled");

	a_root_iterates: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT && !st.iter_last) |=> (state_q == S_ROOT))
		else $error("square root left early");

	a_div_iterates: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !st.iter_last) |=> (state_q == S_DIV))
		else $error("division left early");

endmodule
`default_nettype wire

// ===== src/tmp_dp.sv =====
// Datapath: config, motion state, shared multiplier and bit-serial root/divide unit.
`default_nettype none
module tmp_dp (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  tmp_pkg::item_t                       in_data,
	input  wire                                  cfg_valid,
	input  wire [tmp_pkg::CfgIdxWidth-1:0]       cfg_index,
	input  wire [tmp_pkg::CfgDataWidth-1:0]      cfg_data,
	input  tmp_pkg::dp_cmd_t                     cmd,
	output tmp_pkg::dp_status_t                  st,
	output tmp_pkg::result_t                     out_data
);
	import tmp_pkg::*;

	logic [CfgWidth-1:0]  vmax_q, amax_q, ptol_q, vtol_q;
	logic [TimeWidth-1:0] tmax_q;
	logic signed [ValueWidth-1:0] pos_q, vel_q, tgt_q, nv_q;
	logic init_q, ok_q, ovf_q;
	item_t item_q;
	logic [63:0] mul_q;
	logic [65:0] acc_q;
	logic [35:0] rem_q;
	logic [63:0] quo_q;
	logic [IterWidth-1:0] cnt_q;
	logic signed [32:0] sum_q;
	result_t out_q;

	// error and magnitudes
	logic signed [32:0] err, vel_x;
	logic [32:0] err_mag, vel_mag, sum_mag;
	logic cfg_ok, in_band;

	assign err     = 33'(tgt_q) - 33'(pos_q);
	assign err_mag = err[32] ? 33'(-err) : 33'(err);
	assign vel_x   = 33'(vel_q);
	assign vel_mag = vel_x[32] ? 33'(-vel_x) : 33'(vel_x);
	assign sum_mag = sum_q[32] ? 33'(-sum_q) : 33'(sum_q);
	assign cfg_ok  = (vmax_q != '0) && (amax_q != '0) && (tmax_q != '0) &&
		(ptol_q != '0) && (vtol_q != '0);
	assign in_band = (err_mag <= {2'b00, ptol_q}) && (vel_mag <= {2'b00, vtol_q});

	assign st.kind        = item_q.kind;
	assign st.initialized = init_q;
	assign st.cfg_ok      = cfg_ok;
	assign st.dt_ok       = (item_q.elapsed_time != '0) && (item_q.elapsed_time <= tmax_q);
	assign st.in_band     = in_band;
	assign st.iter_last   = (cnt_q == '0);

	// shared multiplier
	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_p;

	always_comb begin
		mul_a = {2'b00, amax_q};
		mul_b = {8'd0, item_q.elapsed_time};
		case (cmd.op)
			OP_MUL_ERR:  mul_b = err_mag;
			OP_MUL_STEP: mul_a = sum_mag;
			OP_MUL_STOP: begin
				mul_a = vel_mag;
				mul_b = vel_mag;
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// root step
	logic [35:0] r_rem, r_trial;
	logic        r_take;
	assign r_rem   = {rem_q[33:0], acc_q[65:64]};
	assign r_trial = {quo_q[33:0], 2'b01};
	assign r_take  = (r_rem >= r_trial);

	// divide step, divisor 2a
	logic [33:0] d_rem, d_div;
	logic        d_take;
	assign d_rem  = {rem_q[32:0], acc_q[63]};
	assign d_div  = {2'b00, amax_q, 1'b0};
	assign d_take = (d_rem >= d_div);

	// velocity update
	logic [30:0] dm;
	logic signed [34:0] desired, diff, maxdv;
	sat_t nv_sat;

	always_comb begin
		dm = (quo_q[32:0] < {2'b00, vmax_q}) ? quo_q[30:0] : vmax_q;
		desired = err[32] ? -$signed({4'd0, dm}) : $signed({4'd0, dm});
		maxdv = $signed({3'd0, mul_q[55:24]});
		diff = desired - 35'(vel_q);
		if (diff > maxdv)
			diff = maxdv;
		else if (diff < -maxdv)
			diff = -maxdv;
		nv_sat = sat_value(65'(vel_q) + 65'(diff));
	end

	// position update and stop target
	logic signed [33:0] delta;
	logic signed [64:0] stop_dist;
	sat_t pos_sat, tgt_sat;

	assign delta     = sum_q[32] ? -$signed({1'b0, mul_q[57:25]}) : $signed({1'b0, mul_q[57:25]});
	assign pos_sat   = sat_value(65'(pos_q) + 65'(delta));
	assign stop_dist = vel_q[ValueWidth-1] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign tgt_sat   = sat_value(65'(pos_q) + stop_dist);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmax_q <= RST_MAX_VEL;
			amax_q <= RST_MAX_ACC;
			tmax_q <= RST_MAX_DT;
			ptol_q <= RST_POS_TOL;
			vtol_q <= RST_VEL_TOL;
			pos_q  <= '0;
			vel_q  <= '0;
			tgt_q  <= '0;
			init_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MAX_VEL: vmax_q <= cfg_data[CfgWidth-1:0];
					CFG_MAX_ACC: amax_q <= cfg_data[CfgWidth-1:0];
					CFG_MAX_DT:  tmax_q <= cfg_data[TimeWidth-1:0];
					CFG_POS_TOL: ptol_q <= cfg_data[CfgWidth-1:0];
					CFG_VEL_TOL: vtol_q <= cfg_data[CfgWidth-1:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_INIT: begin
					pos_q  <= item_q.start_position;
					tgt_q  <= item_q.start_position;
					vel_q  <= '0;
					init_q <= 1'b1;
				end
				OP_SET_TARGET: tgt_q <= item_q.goal_position;
				OP_SNAP: begin
					pos_q <= tgt_q;
					vel_q <= '0;
				end
				OP_POS: begin
					pos_q <= pos_sat.v;
					vel_q <= nv_q;
				end
				OP_STOP_ADD: tgt_q <= tgt_sat.v;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op) inside
			OP_LOAD: item_q <= in_data;
			OP_INIT, OP_SET_TARGET, OP_SNAP: ok_q <= 1'b1;
			OP_REJECT: ok_q <= 1'b0;
			OP_MUL_ERR: begin
				mul_q <= mul_p[63:0];
				cnt_q <= IterWidth'(RootSteps - 1);
			end
			OP_MUL_DT: begin
				acc_q <= {1'b0, mul_q, 1'b0};
				rem_q <= '0;
				quo_q <= '0;
				mul_q <= mul_p[63:0];
			end
			OP_ROOT_STEP: begin
				rem_q <= r_take ? (r_rem - r_trial) : r_rem;
				quo_q <= {quo_q[62:0], r_take};
				acc_q <= {acc_q[63:0], 2'b00};
				cnt_q <= cnt_q - 1'b1;
			end
			OP_VEL: begin
				nv_q  <= nv_sat.v;
				ovf_q <= nv_sat.ovf;
				sum_q <= 33'(vel_q) + 33'(nv_sat.v);
			end
			OP_MUL_STEP, OP_MUL_STOP: mul_q <= mul_p[63:0];
			OP_POS: ok_q <= !(ovf_q || pos_sat.ovf);
			OP_DIV_LOAD: begin
				acc_q <= {2'b00, mul_q};
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= IterWidth'(DivSteps - 1);
			end
			OP_DIV_STEP: begin
				rem_q <= {2'b00, (d_take ? (d_rem - d_div) : d_rem)};
				quo_q <= {quo_q[62:0], d_take};
				acc_q <= {acc_q[64:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			OP_STOP_ADD: ok_q <= !tgt_sat.ovf;
			default: ;
		endcase
		if (cmd.out_load) begin
			out_q.ok           <= ok_q;
			out_q.position_out <= pos_q;
			out_q.velocity_out <= vel_q;
			out_q.settled      <= init_q && cfg_ok && in_band;
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== dv/trapezoidal_motion_profile_test.sv =====
// Testbench for the trapezoidal motion profile generator: directed and random events, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none
module trapezoidal_motion_profile_test;
	import tmp_pkg::*;

	// profile scoreboard: holds the motion state and the expected result beats
	class profile_scoreboard;
		logic signed [63:0] pos, vel, tgt;
		bit                 armed;
		logic [63:0]        vmax, amax, dtmax, ptol, vtol;
		result_t            pending[$];
		int                 errors;

		function void clear();
			pos = 0; vel = 0; tgt = 0; armed = 0;
			vmax = RST_MAX_VEL; amax = RST_MAX_ACC; dtmax = RST_MAX_DT;
			ptol = RST_POS_TOL; vtol = RST_VEL_TOL;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [31:0] val);
			case (idx)
				CFG_MAX_VEL: vmax = val[30:0];
				CFG_MAX_ACC: amax = val[30:0];
				CFG_MAX_DT:  dtmax = val[24:0];
				CFG_POS_TOL: ptol = val[30:0];
				CFG_VEL_TOL: vtol = val[30:0];
				default: ;
			endcase
		endfunction

		function bit regs_ok();
			return vmax != 0 && amax != 0 && dtmax != 0 && ptol != 0 && vtol != 0;
		endfunction

		function logic [63:0] magn(logic signed [63:0] x);
			return x < 0 ? -x : x;
		endfunction

		function logic signed [63:0] clip(logic signed [63:0] x, ref bit ovf);
			if (x > 64'sd2147483647) begin
				ovf = 1; return 64'sd2147483647;
			end
			if (x < -64'sd2147483648) begin
				ovf = 1; return -64'sd2147483648;
			end
			return x;
		endfunction

		// notes an accepted event and queues what it must produce
		function void note_event(item_t it);
			bit ok, ovf;
			logic [127:0] sq, prod;
			logic [127:0] dq;
			logic [63:0] root, cand, dm, av, stop_len, maxdv, dmag;
			logic signed [63:0] e, desired, diff, nv, sum, delta, sd;
			logic [63:0] dt;
			result_t r;
			ok = 0; ovf = 0;
			dt = it.elapsed_time;
			case (it.kind)
				KIND_INIT: begin
					pos = it.start_position; tgt = pos; vel = 0; armed = 1; ok = 1;
				end
				KIND_TARGET: if (armed) begin
					tgt = it.goal_position; ok = 1;
				end
				KIND_STOP: if (armed && regs_ok()) begin
					av = magn(vel);
					dq = ({64'd0, av} * av) / (2 * amax);
					stop_len = (dq > (128'd1 << 62)) ? (64'd1 << 62) : dq[63:0];
					sd = vel < 0 ? -$signed(stop_len) : $signed(stop_len);
					tgt = clip(pos + sd, ovf);
					ok = !ovf;
				end
				default: if (armed && regs_ok() && dt != 0 && dt <= dtmax) begin
					e = tgt - pos;
					if (magn(e) <= ptol && magn(vel) <= vtol) begin
						pos = tgt; vel = 0;
					end else begin
						// floored root of 2a|e|, bit by bit
						sq = {64'd0, 2 * amax} * magn(e);
						root = 0;
						for (int i = 41; i >= 0; i--) begin
							cand = root | (64'd1 << i);
							if ({64'd0, cand} * cand <= sq) root = cand;
						end
						dm = root < vmax ? root : vmax;
						desired = e < 0 ? -$signed(dm) : $signed(dm);
						maxdv = (amax * dt) >> 24;
						diff = desired - vel;
						if (diff > $signed(maxdv)) diff = maxdv;
						if (diff < -$signed(maxdv)) diff = -$signed(maxdv);
						nv = clip(vel + diff, ovf);
						sum = vel + nv;
						prod = {64'd0, magn(sum)} * dt;
						dmag = prod[88:25];
						delta = sum < 0 ? -$signed(dmag) : $signed(dmag);
						vel = nv;
						pos = clip(pos + delta, ovf);
					end
					ok = !ovf;
				end
			endcase
			r.ok = ok;
			r.position_out = pos[31:0];
			r.velocity_out = vel[31:0];
			r.settled = armed && regs_ok() && magn(tgt - pos) <= ptol && magn(vel) <= vtol;
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.ok !== want.ok) begin
				$error("ok: expected %0d actual %0d", want.ok, got.ok); errors++;
			end
			if (got.position_out !== want.position_out) begin
				$error("position_out: expected %0d actual %0d",
					want.position_out, got.position_out);
				errors++;
			end
			if (got.velocity_out !== want.velocity_out) begin
				$error("velocity_out: expected %0d actual %0d",
					want.velocity_out, got.velocity_out);
				errors++;
			end
			if (got.settled !== want.settled) begin
				$error("settled: expected %0d actual %0d", want.settled, got.settled);
				errors++;
			end
		endfunction
	endclass

	localparam int WatchLimit = 20000;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_valid = 0;
	logic in_stall, out_valid, cfg_ready;
	item_t in_data = '0;
	result_t out_data;
	logic [CfgIdxWidth-1:0] cfg_index = '0;
	logic [CfgDataWidth-1:0] cfg_data = '0;

	int send_idle = 0, recv_idle = 0; // idle percentages
	int quiet = 0;
	bit timed_out = 0;
	profile_scoreboard board;

	trapezoidal_motion_profile dut (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #2 clk = ~clk;

	// receiver: random stall, check every accepted result beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) board.check_result(out_data);
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WatchLimit) begin
			$display("[trapezoidal_motion_profile] ERROR");
			$finish;
		end
	end

	// valid stays up after the beat until the next event or an idle cycle drops it
	task automatic send_event(item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		board.note_event(it);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk); // longer than the stop latency
	endtask

	task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic item_t make_event(kind_t k, logic [31:0] p, logic [31:0] g,
		logic [24:0] dt);
		item_t it;
		it.kind = k;
		it.start_position = p;
		it.goal_position = g;
		it.elapsed_time = dt;
		return it;
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(200000)
				: 32'h8000_0000 + $urandom_range(200000);
			default: return $signed($urandom_range(2000000)) - 1000000;
		endcase
	endfunction

	function automatic item_t rand_event(int dtmax);
		int pick;
		logic [24:0] dt;
		pick = $urandom_range(99);
		dt = ($urandom_range(19) == 0) ? 25'($urandom) : 25'($urandom_range(1, dtmax));
		if (pick < 4) return make_event(KIND_INIT, rand_pos(), $urandom, dt);
		if (pick < 12) return make_event(KIND_TARGET, $urandom, rand_pos(), dt);
		if (pick < 17) return make_event(KIND_STOP, $urandom, $urandom, dt);
		return make_event(KIND_TICK, $urandom, $urandom, dt);
	endfunction

	task automatic random_phase(int n, int dtmax);
		repeat (n) send_event(rand_event(dtmax));
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: uninitialized rejects, then extremes and special cases
		send_event(make_event(KIND_TICK, 0, 0, 100));
		send_event(make_event(KIND_STOP, 0, 0, 0));
		send_event(make_event(KIND_TARGET, 0, 32'h7FFF_FFFF, 0));
		send_event(make_event(KIND_INIT, 32'h8000_0000, 0, 0));
		send_event(make_event(KIND_TARGET, 0, 32'h7FFF_FFFF, 0));
		send_event(make_event(KIND_TICK, 0, 0, 0));                // zero duration
		send_event(make_event(KIND_TICK, 0, 0, 167773));           // above limit
		send_event(make_event(KIND_TICK, 0, 0, 25'h1FF_FFFF));
		repeat (4) send_event(make_event(KIND_TICK, 0, 0, 167772));
		send_event(make_event(KIND_STOP, 0, 0, 0));
		send_event(make_event(KIND_INIT, 32'h7FFF_FFF0, 0, 0));
		send_event(make_event(KIND_TARGET, 0, 32'h8000_0000, 0));
		repeat (3) send_event(make_event(KIND_TICK, 0, 0, 1));
		send_event(make_event(KIND_INIT, 0, 0, 0));
		send_event(make_event(KIND_TARGET, 0, 40, 0));
		send_event(make_event(KIND_TICK, 0, 0, 16));               // dead band snap
		send_event(make_event(KIND_TARGET, 0, 32'hFFF0_0000, 0));
		send_event(make_event(KIND_TICK, 0, 0, 100000));
		send_event(make_event(KIND_STOP, 0, 0, 0));
		drain(); // sender waits for every result

		send_idle = 34; recv_idle = 62;
		random_phase(180, 167772);
		drain();

		// extreme registers: large limits and long ticks
		write_reg(CFG_MAX_VEL, 32'h7FFF_FFFF);
		write_reg(CFG_MAX_ACC, 32'hFFFF_FFFF);
		write_reg(CFG_MAX_DT, 25'h100_0000);
		write_reg(CFG_POS_TOL, 32'h7FFF_FFFF);
		write_reg(CFG_VEL_TOL, 1);
		send_idle = 62; recv_idle = 34;
		random_phase(90, 25'h100_0000);
		drain();

		// smallest nonzero limits (velocity tolerance at its largest), then one zero register
		write_reg(CFG_MAX_VEL, 1);
		write_reg(CFG_MAX_ACC, 1);
		write_reg(CFG_MAX_DT, 1);
		write_reg(CFG_POS_TOL, 1);
		write_reg(CFG_VEL_TOL, 32'h7FFF_FFFF);
		random_phase(40, 1);
		drain();
		write_reg(CFG_MAX_ACC, 0);
		random_phase(30, 100);
		drain();

		// moderate random setting, no idling
		write_reg(CFG_MAX_VEL, $urandom_range(1, 32'h0100_0000));
		write_reg(CFG_MAX_ACC, $urandom_range(1, 32'h1000_0000));
		write_reg(CFG_MAX_DT, $urandom_range(1000, 1000000));
		write_reg(CFG_POS_TOL, $urandom_range(1, 5000));
		write_reg(CFG_VEL_TOL, $urandom_range(1, 50000));
		send_idle = 0; recv_idle = 0;
		random_phase(200, 1000000);
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("[trapezoidal_motion_profile] OK");
		else
			$display("[trapezoidal_motion_profile] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
